/* src/pvc_pkg.sv */
// Package for the pump and valve controller.
// Holds operation codes, register indexes and the command word type.
// No dependencies.
package pvc_pkg;

	localparam int OP_W        = 2;
	localparam int IDX_W       = 8;
	localparam int VAL_W       = 8;
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 8;
	localparam int TIMER_W     = 8;

	// Operation codes
	localparam logic [OP_W-1:0] OP_PUMP   = 2'd0;
	localparam logic [OP_W-1:0] OP_SENSE  = 2'd1;
	localparam logic [OP_W-1:0] OP_TICK   = 2'd2;
	localparam logic [OP_W-1:0] OP_STATUS = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_AUTOCLOSE = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 4'd1;

	// Register reset values
	localparam logic [CFG_DATA_W-1:0] AUTOCLOSE_RESET = 8'd5;
	localparam logic [CFG_DATA_W-1:0] THRESHOLD_RESET = 8'd150;

	// Pump command value that switches a pump on
	localparam logic [VAL_W-1:0] PUMP_ON_VALUE = 8'd1;

	// Command part of an item word
	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [IDX_W-1:0] idx;
		logic [VAL_W-1:0] val;
	} cmd_t;

	// Configuration register values
	typedef struct packed {
		logic [CFG_DATA_W-1:0] autoclose;
		logic [CFG_DATA_W-1:0] threshold;
	} cfg_t;

endpackage

/* src/pvc_history.sv */
// Sense history memory for the pump and valve controller: WINDOW entries of
// one bit per channel, a write pointer and a wrapped flag standing in for reset.
// Depends on no other file; all widths are passed in as parameters.
module pvc_history #(
	parameter int CHANNELS = 6,
	parameter int WINDOW   = 200
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  logic                wr_en,
	input  logic [CHANNELS-1:0] wr_data,
	output logic [CHANNELS-1:0] old_bits
);

	localparam int PW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

	logic [CHANNELS-1:0] mem [WINDOW];
	logic [PW-1:0]       ptr_q;
	logic                wrapped_q;
	logic [PW-1:0]       addr_s1;
	logic                old_valid_s1;
	logic [CHANNELS-1:0] rdata_s1;

	// Advance the pointer on every sample read; set the wrapped flag on the first wrap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q     <= '0;
			wrapped_q <= 1'b0;
		end else if (rd_en) begin
			if (ptr_q == PW'(WINDOW - 1)) begin
				ptr_q     <= '0;
				wrapped_q <= 1'b1;
			end else begin
				ptr_q <= ptr_q + 1'b1;
			end
		end
	end

	// Read the oldest entry; hold address and data for the write-back stage
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_s1     <= mem[ptr_q];
			addr_s1      <= ptr_q;
			old_valid_s1 <= wrapped_q;
		end
	end

	// Write the new sample over the entry just read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr_s1] <= wr_data;
		end
	end

	// An entry not yet written since reset reads as zero
	assign old_bits = old_valid_s1 ? rdata_s1 : '0;

endmodule

/* src/pvc_channels.sv */
// Per-channel state of the pump and valve controller: pump and valve bits,
// auto-close timers and window counts. Depends on pvc_pkg.
module pvc_channels #(
	parameter int CHANNELS = 6,
	parameter int WINDOW   = 200
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                update,
	input  pvc_pkg::cmd_t       cmd,
	input  logic [CHANNELS-1:0] sense,
	input  logic [CHANNELS-1:0] old_bits,
	input  pvc_pkg::cfg_t       cfg,
	output logic [CHANNELS-1:0] pump_next,
	output logic [CHANNELS-1:0] valve_next,
	output logic [CHANNELS-1:0] detected_next
);

	localparam int CW   = $clog2(WINDOW + 1);
	localparam int CMPW = (CW > pvc_pkg::CFG_DATA_W) ? CW : pvc_pkg::CFG_DATA_W;

	logic [CHANNELS-1:0]          pump_q;
	logic [CHANNELS-1:0]          valve_q;
	logic [CHANNELS-1:0]          active_q;
	logic [pvc_pkg::TIMER_W-1:0]  timer_q      [CHANNELS];
	logic [CW-1:0]                count_q      [CHANNELS];
	logic [CHANNELS-1:0]          active_next;
	logic [pvc_pkg::TIMER_W-1:0]  timer_next   [CHANNELS];
	logic [CW-1:0]                count_next   [CHANNELS];
	logic [pvc_pkg::TIMER_W-1:0]  timer_inc    [CHANNELS];

	// Compute next state for each channel
	always_comb begin
		for (int ch = 0; ch < CHANNELS; ch++) begin
			pump_next[ch]   = pump_q[ch];
			valve_next[ch]  = valve_q[ch];
			active_next[ch] = active_q[ch];
			timer_next[ch]  = timer_q[ch];
			count_next[ch]  = count_q[ch];
			timer_inc[ch]   = timer_q[ch] + 1'b1;
			case (cmd.op)
				pvc_pkg::OP_PUMP: begin
					if (cmd.idx == pvc_pkg::IDX_W'(ch)) begin
						if (cmd.val == pvc_pkg::PUMP_ON_VALUE) begin
							pump_next[ch] = 1'b1;
						end else begin
							pump_next[ch]   = 1'b0;
							valve_next[ch]  = 1'b1;
							active_next[ch] = 1'b1;
							timer_next[ch]  = '0;
						end
					end
				end
				pvc_pkg::OP_SENSE: begin
					count_next[ch] = count_q[ch] + CW'(sense[ch]) - CW'(old_bits[ch]);
				end
				pvc_pkg::OP_TICK: begin
					if (active_q[ch]) begin
						if (timer_inc[ch] == cfg.autoclose) begin
							active_next[ch] = 1'b0;
							timer_next[ch]  = '0;
							valve_next[ch]  = 1'b0;
						end else begin
							timer_next[ch] = timer_inc[ch];
						end
					end
				end
				default: begin
				end
			endcase
			detected_next[ch] = CMPW'(count_next[ch]) > CMPW'(cfg.threshold);
		end
	end

	// Commit next state when the item leaves the stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pump_q   <= '0;
			valve_q  <= '0;
			active_q <= '0;
			for (int ch = 0; ch < CHANNELS; ch++) begin
				timer_q[ch] <= '0;
				count_q[ch] <= '0;
			end
		end else if (update) begin
			pump_q   <= pump_next;
			valve_q  <= valve_next;
			active_q <= active_next;
			for (int ch = 0; ch < CHANNELS; ch++) begin
				timer_q[ch] <= timer_next[ch];
				count_q[ch] <= count_next[ch];
			end
		end
	end

endmodule

/* src/pump_valve_controller.sv */
// Top level of the pump and valve controller: handshake, configuration
// registers, one working stage and the result register.
// Depends on pvc_pkg, pvc_history and pvc_channels.
//
//   channel   direction  handshake                    payload
//   item      in         item_valid / item_stall      operation, pump_index,
//                                                     pump_value, pump_sense
//   result    out        result_valid / result_stall  pump_drive, valve_drive,
//                                                     current_detected, is_report
//   config    in         cfg_write                    cfg_index, cfg_data
//
// One word is accepted per cycle while item_stall is low; results are registered.
// The history memory is read when a sample is accepted and written back at the
// same address when the sample leaves the working stage, so consecutive samples
// never touch one entry.
// After reset the block takes words at once; unwritten history reads as zero.
// A stalled result holds the working stage, and item_stall rises only then.
module pump_valve_controller #(
	parameter int CHANNELS = 6,
	parameter int WINDOW   = 200
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_stall,
	input  logic [pvc_pkg::OP_W-1:0]           operation,
	input  logic [pvc_pkg::IDX_W-1:0]          pump_index,
	input  logic [pvc_pkg::VAL_W-1:0]          pump_value,
	input  logic [CHANNELS-1:0]                pump_sense,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic [CHANNELS-1:0]                pump_drive,
	output logic [CHANNELS-1:0]                valve_drive,
	output logic [CHANNELS-1:0]                current_detected,
	output logic                               is_report,
	input  logic                               cfg_write,
	input  logic [pvc_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [pvc_pkg::CFG_DATA_W-1:0]     cfg_data
);

	pvc_pkg::cfg_t       cfg_q;
	pvc_pkg::cmd_t       cmd_s1;
	logic [CHANNELS-1:0] sense_s1;
	logic                valid_s1;
	logic                out_valid_q;
	logic                advance;
	logic                accept;
	logic                adv_s1;
	logic [CHANNELS-1:0] old_bits;
	logic [CHANNELS-1:0] pump_next;
	logic [CHANNELS-1:0] valve_next;
	logic [CHANNELS-1:0] detected_next;

	// Stage moves on when the result register is free or being taken
	assign advance    = !out_valid_q || !result_stall;
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;
	assign adv_s1     = valid_s1 && advance;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.autoclose <= pvc_pkg::AUTOCLOSE_RESET;
			cfg_q.threshold <= pvc_pkg::THRESHOLD_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				pvc_pkg::REG_AUTOCLOSE: cfg_q.autoclose <= cfg_data;
				pvc_pkg::REG_THRESHOLD: cfg_q.threshold <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Working stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !advance);
		end
	end

	// Load the item word
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.op  <= operation;
			cmd_s1.idx <= pump_index;
			cmd_s1.val <= pump_value;
			sense_s1   <= pump_sense;
		end
	end

	pvc_history #(
		.CHANNELS (CHANNELS),
		.WINDOW   (WINDOW)
	) u_history (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept && (operation == pvc_pkg::OP_SENSE)),
		.wr_en    (adv_s1 && (cmd_s1.op == pvc_pkg::OP_SENSE)),
		.wr_data  (sense_s1),
		.old_bits (old_bits)
	);

	pvc_channels #(
		.CHANNELS (CHANNELS),
		.WINDOW   (WINDOW)
	) u_channels (
		.clk           (clk),
		.arst_n        (arst_n),
		.update        (adv_s1),
		.cmd           (cmd_s1),
		.sense         (sense_s1),
		.old_bits      (old_bits),
		.cfg           (cfg_q),
		.pump_next     (pump_next),
		.valve_next    (valve_next),
		.detected_next (detected_next)
	);

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	// Capture the result word
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			pump_drive       <= pump_next;
			valve_drive      <= valve_next;
			current_detected <= detected_next;
			is_report        <= (cmd_s1.op == pvc_pkg::OP_STATUS);
		end
	end

	assign result_valid = out_valid_q;

endmodule

/* bench/pvc_checker.sv */
// Checker for the pump and valve controller: predicts every result word and compares it.
// Watches the item, result and register write ports; depends on pvc_pkg only.
module pvc_checker #(
	parameter int CHANNELS = 6,
	parameter int WINDOW   = 200
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	input  logic                            item_stall,
	input  logic [pvc_pkg::OP_W-1:0]        operation,
	input  logic [pvc_pkg::IDX_W-1:0]       pump_index,
	input  logic [pvc_pkg::VAL_W-1:0]       pump_value,
	input  logic [CHANNELS-1:0]             pump_sense,
	input  logic                            result_valid,
	input  logic                            result_stall,
	input  logic [CHANNELS-1:0]             pump_drive,
	input  logic [CHANNELS-1:0]             valve_drive,
	input  logic [CHANNELS-1:0]             current_detected,
	input  logic                            is_report,
	input  logic                            cfg_write,
	input  logic [pvc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [pvc_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                              mismatches,
	output int                              pending,
	output int                              results_checked,
	output int                              reports_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	import pvc_pkg::*;

	localparam int SLOT_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int WPW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;

	typedef struct packed {
		logic [CHANNELS-1:0] pumps;
		logic [CHANNELS-1:0] valves;
		logic [CHANNELS-1:0] detected;
		logic                report;
	} drive_word_t;

	// Predicted controller state and register copies
	drive_word_t           drive_queue[$];
	logic [CHANNELS-1:0]   pump_on;
	logic [CHANNELS-1:0]   valve_open;
	logic [CHANNELS-1:0]   timer_run;
	logic [TIMER_W-1:0]    timer_ticks [CHANNELS];
	logic [CHANNELS-1:0]   window_bits [WINDOW];
	int                    window_count [CHANNELS];
	logic [WPW-1:0]        window_slot;
	logic [CFG_DATA_W-1:0] close_after;
	logic [CFG_DATA_W-1:0] detect_above;

	int fail_count = 0;
	int word_count = 0;
	int report_count = 0;

	assign mismatches      = fail_count;
	assign results_checked = word_count;
	assign reports_checked = report_count;

	// Print one line per mismatch and count it
	task automatic flag_mismatch(input string what, input int got, input int want);
		$display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		drive_word_t         want;
		drive_word_t         next_word;
		logic [CHANNELS-1:0] oldest;
		logic [SLOT_W-1:0]   slot;
		if (!arst_n) begin
			pump_on      = '0;
			valve_open   = '0;
			timer_run    = '0;
			window_slot  = '0;
			close_after  = AUTOCLOSE_RESET;
			detect_above = THRESHOLD_RESET;
			for (int ch = 0; ch < CHANNELS; ch++) begin
				timer_ticks[ch]  = '0;
				window_count[ch] = 0;
			end
			for (int w = 0; w < WINDOW; w++) begin
				window_bits[w] = '0;
			end
			drive_queue.delete();
			pending <= 0;
		end else begin
			// Compare an accepted result word with the oldest prediction
			if (result_valid && !result_stall) begin
				if (drive_queue.size() == 0) begin
					flag_mismatch("unrequested result word", 1, 0);
				end else begin
					want = drive_queue.pop_front();
					if (pump_drive !== want.pumps)
						flag_mismatch("pump_drive", int'(pump_drive), int'(want.pumps));
					if (valve_drive !== want.valves)
						flag_mismatch("valve_drive", int'(valve_drive), int'(want.valves));
					if (current_detected !== want.detected)
						flag_mismatch("current_detected", int'(current_detected),
							int'(want.detected));
					if (is_report !== want.report)
						flag_mismatch("is_report", int'(is_report), int'(want.report));
					word_count++;
					if (want.report)
						report_count++;
				end
			end

			// Track register writes
			if (cfg_write) begin
				if (cfg_index == REG_AUTOCLOSE)
					close_after = cfg_data;
				else if (cfg_index == REG_THRESHOLD)
					detect_above = cfg_data;
			end

			// Advance the predicted state by one accepted item word
			if (item_valid && !item_stall) begin
				case (operation)
					OP_PUMP: begin
						if (pump_index < CHANNELS) begin
							slot = pump_index[SLOT_W-1:0];
							if (pump_value == PUMP_ON_VALUE) begin
								pump_on[slot] = 1'b1;
							end else begin
								pump_on[slot]     = 1'b0;
								valve_open[slot]  = 1'b1;
								timer_run[slot]   = 1'b1;
								timer_ticks[slot] = '0;
							end
						end
					end
					OP_SENSE: begin
						oldest = window_bits[window_slot];
						for (int ch = 0; ch < CHANNELS; ch++) begin
							window_count[ch] = window_count[ch] + int'(pump_sense[ch])
								- int'(oldest[ch]);
						end
						window_bits[window_slot] = pump_sense;
						window_slot = (window_slot == WPW'(WINDOW - 1)) ? '0
							: window_slot + 1'b1;
					end
					OP_TICK: begin
						for (int ch = 0; ch < CHANNELS; ch++) begin
							if (timer_run[ch]) begin
								timer_ticks[ch] = timer_ticks[ch] + 1'b1;
								if (timer_ticks[ch] == close_after) begin
									timer_run[ch]   = 1'b0;
									timer_ticks[ch] = '0;
									valve_open[ch]  = 1'b0;
								end
							end
						end
					end
					default: begin
					end
				endcase
				next_word.pumps  = pump_on;
				next_word.valves = valve_open;
				for (int ch = 0; ch < CHANNELS; ch++) begin
					next_word.detected[ch] = window_count[ch] > int'(detect_above);
				end
				next_word.report = (operation == OP_STATUS);
				drive_queue.push_back(next_word);
			end

			pending <= drive_queue.size();
		end
	end

endmodule

/* bench/pump_valve_controller_tb.sv */
// Testbench top for the pump and valve controller: clock, reset, item and register stimulus,
// result stalls and the verdict. Depends on pvc_pkg, pvc_checker and the controller RTL.
module pump_valve_controller_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pvc_pkg::*;

	localparam int CHANNELS      = 6;
	localparam int WINDOW        = 200;
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int SETTLE_CYCLES = 6;
	localparam int SQUEEZE_LEN   = 150;

	logic                   clk;
	logic                   arst_n;
	logic                   item_valid;
	logic                   item_stall;
	logic [OP_W-1:0]        operation;
	logic [IDX_W-1:0]       pump_index;
	logic [VAL_W-1:0]       pump_value;
	logic [CHANNELS-1:0]    pump_sense;
	logic                   result_valid;
	logic                   result_stall;
	logic [CHANNELS-1:0]    pump_drive;
	logic [CHANNELS-1:0]    valve_drive;
	logic [CHANNELS-1:0]    current_detected;
	logic                   is_report;
	logic                   cfg_write;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	int mismatches;
	int pending;
	int results_checked;
	int reports_checked;
	int cycle_count = 0;
	int words_sent = 0;
	bit steady_input = 1'b0;
	bit squeeze_request = 1'b0;

	pump_valve_controller #(
		.CHANNELS(CHANNELS),
		.WINDOW  (WINDOW)
	) dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_stall      (item_stall),
		.operation       (operation),
		.pump_index      (pump_index),
		.pump_value      (pump_value),
		.pump_sense      (pump_sense),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.pump_drive      (pump_drive),
		.valve_drive     (valve_drive),
		.current_detected(current_detected),
		.is_report       (is_report),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	pvc_checker #(
		.CHANNELS(CHANNELS),
		.WINDOW  (WINDOW)
	) drive_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_stall      (item_stall),
		.operation       (operation),
		.pump_index      (pump_index),
		.pump_value      (pump_value),
		.pump_sense      (pump_sense),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.pump_drive      (pump_drive),
		.valve_drive     (valve_drive),
		.current_detected(current_detected),
		.is_report       (is_report),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mismatches      (mismatches),
		.pending         (pending),
		.results_checked (results_checked),
		.reports_checked (reports_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", CYCLE_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		else if (roll < 85)
			return $urandom_range(1, 3);
		else if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Offer one item word, hold it until taken, then maybe idle
	task automatic offer(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
			input logic [VAL_W-1:0] val, input logic [CHANNELS-1:0] sense);
		int gap;
		item_valid <= 1'b1;
		operation  <= op;
		pump_index <= idx;
		pump_value <= val;
		pump_sense <= sense;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		words_sent++;
		if (words_sent % 64 == 0)
			steady_input = ($urandom_range(0, 3) == 0);
		gap = steady_input ? 0 : pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid and wait until every predicted word has come back
	task automatic settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	// Change both registers with the block idle
	task automatic tune(input logic [CFG_DATA_W-1:0] close, input logic [CFG_DATA_W-1:0] thresh);
		settle();
		write_reg(REG_AUTOCLOSE, close);
		write_reg(REG_THRESHOLD, thresh);
	endtask

	// Random mix of commands, samples and ticks; sense density fixed per channel for the run
	task automatic run_random(input int count);
		int                  odds [CHANNELS];
		int                  roll;
		logic [OP_W-1:0]     op;
		logic [IDX_W-1:0]    idx;
		logic [VAL_W-1:0]    val;
		logic [CHANNELS-1:0] sense;
		for (int ch = 0; ch < CHANNELS; ch++) begin
			case ($urandom_range(0, 5))
				0:       odds[ch] = 0;
				1:       odds[ch] = 10;
				2:       odds[ch] = 50;
				3:       odds[ch] = 85;
				4:       odds[ch] = 97;
				default: odds[ch] = 100;
			endcase
		end
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(0, 99);
			if (roll < 25)
				op = OP_PUMP;
			else if (roll < 70)
				op = OP_SENSE;
			else if (roll < 90)
				op = OP_TICK;
			else
				op = OP_STATUS;
			if ($urandom_range(0, 9) < 8)
				idx = IDX_W'($urandom_range(0, CHANNELS - 1));
			else
				idx = IDX_W'($urandom_range(0, 255));
			roll = $urandom_range(0, 9);
			if (roll < 4)
				val = PUMP_ON_VALUE;
			else if (roll < 8)
				val = '0;
			else
				val = VAL_W'($urandom_range(0, 255));
			for (int ch = 0; ch < CHANNELS; ch++) begin
				sense[ch] = ($urandom_range(0, 99) < odds[ch]);
			end
			offer(op, idx, val, sense);
		end
	endtask

	// Result side: random stalls, plus one long hold-off on request
	initial begin
		int stall_len;
		int run_len;
		result_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (squeeze_request) begin
				squeeze_request = 1'b0;
				stall_len = SQUEEZE_LEN;
			end else begin
				stall_len = pick_gap();
			end
			if ($urandom_range(0, 3) == 0)
				run_len = $urandom_range(20, 80);
			else
				run_len = $urandom_range(1, 6);
			if (stall_len > 0) begin
				result_stall <= 1'b1;
				repeat (stall_len) @(posedge clk);
			end
			result_stall <= 1'b0;
			repeat (run_len) @(posedge clk);
		end
	end

	initial begin
		arst_n     <= 1'b0;
		item_valid <= 1'b0;
		operation  <= OP_PUMP;
		pump_index <= '0;
		pump_value <= '0;
		pump_sense <= '0;
		cfg_write  <= 1'b0;
		cfg_index  <= REG_AUTOCLOSE;
		cfg_data   <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: index limits, on and off values, repeated shutdown, valve closing
		offer(OP_PUMP, 8'd0, PUMP_ON_VALUE, CHANNELS'($urandom));
		offer(OP_PUMP, 8'd5, PUMP_ON_VALUE, CHANNELS'($urandom));
		offer(OP_PUMP, 8'd6, PUMP_ON_VALUE, CHANNELS'($urandom));
		offer(OP_PUMP, 8'd255, 8'd0, CHANNELS'($urandom));
		offer(OP_PUMP, 8'd0, 8'd0, CHANNELS'($urandom));
		offer(OP_TICK, IDX_W'($urandom), VAL_W'($urandom), CHANNELS'($urandom));
		offer(OP_PUMP, 8'd0, 8'd255, CHANNELS'($urandom));
		offer(OP_PUMP, 8'd5, 8'd2, CHANNELS'($urandom));
		offer(OP_PUMP, 8'd5, PUMP_ON_VALUE, CHANNELS'($urandom));
		offer(OP_SENSE, IDX_W'($urandom), VAL_W'($urandom), 6'h3f);
		offer(OP_SENSE, IDX_W'($urandom), VAL_W'($urandom), 6'h00);
		offer(OP_SENSE, IDX_W'($urandom), VAL_W'($urandom), 6'h2a);
		offer(OP_SENSE, IDX_W'($urandom), VAL_W'($urandom), 6'h15);
		repeat (5) offer(OP_TICK, IDX_W'($urandom), VAL_W'($urandom), CHANNELS'($urandom));
		offer(OP_STATUS, 8'd0, 8'd0, 6'h00);
		offer(OP_PUMP, 8'd3, 8'd128, CHANNELS'($urandom));
		offer(OP_STATUS, 8'd255, 8'd255, 6'h3f);

		// Hold the result side off while words keep coming
		squeeze_request = 1'b1;
		run_random(260);

		// Fastest close, lowest threshold
		tune(8'd1, 8'd0);
		run_random(180);

		// Longest nonzero close setting, threshold at the window size
		tune(8'd255, 8'd200);
		run_random(180);

		// Zero auto-close wraps at 256 ticks; a dense window passes threshold 199
		tune(8'd0, 8'd199);
		offer(OP_PUMP, 8'd2, 8'd0, CHANNELS'($urandom));
		offer(OP_PUMP, 8'd3, PUMP_ON_VALUE, CHANNELS'($urandom));
		for (int n = 0; n < 260; n++) begin
			offer(OP_TICK, IDX_W'($urandom), VAL_W'($urandom), CHANNELS'($urandom));
			if (n < WINDOW)
				offer(OP_SENSE, IDX_W'($urandom), VAL_W'($urandom), 6'h2f);
			if (n % 25 == 0)
				offer(OP_STATUS, IDX_W'($urandom), VAL_W'($urandom), CHANNELS'($urandom));
		end

		// Default threshold again while the full window drains
		tune(CFG_DATA_W'($urandom_range(2, 20)), THRESHOLD_RESET);
		run_random(300);

		settle();
		$display("Drove %0d item words, checked %0d result words, %0d of them status reports.",
			words_sent, results_checked, reports_checked);
		$display("Auto-close ran at 0, 1, 5, 255 and a mid value; thresholds 0, 150, 199, 200.");
		if (mismatches == 0 && pending == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

/* files.f */
src/pvc_pkg.sv
src/pvc_history.sv
src/pvc_channels.sv
src/pump_valve_controller.sv
bench/pvc_checker.sv
bench/pump_valve_controller_tb.sv
